[hdl/rhc_pkg.sv]
// Shared constants and payload types for the RGB / hue-lightness-chroma converter.
`timescale 1ns / 1ps

package rhc_pkg;

  // Bits per channel; a channel x means x/(2^ChannelBits-1), a hue x means x/2^ChannelBits.
  localparam int ChannelBits = 12;

  typedef struct packed {
    logic [ChannelBits-1:0] chan_a;
    logic [ChannelBits-1:0] chan_b;
    logic [ChannelBits-1:0] chan_c;
  } pix_in_t;

  typedef struct packed {
    logic [ChannelBits-1:0] out_a;
    logic [ChannelBits-1:0] out_b;
    logic [ChannelBits-1:0] out_c;
  } pix_out_t;

endpackage

[hdl/rgb_hls_color_convert.sv]
// Pipelined RGB to hue/lightness/chroma converter and its inverse.
// Throughput: one transaction per clock; busy is always low since the pipe never stalls.
// The hue divider is a pipelined restoring divider, one quotient bit per stage.
// Reset clears the valid bits and the direction register (forward conversion).
// The receiver cannot stall: each result is shown for exactly one cycle with done_o.
`timescale 1ns / 1ps

module rgb_hls_color_convert (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rhc_pkg::pix_in_t  pix_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  output logic              done_o,
  output rhc_pkg::pix_out_t pix_o
);

  // W: channel width. Q: quotient bits of the hue division (hue can round up to a full turn).
  // RW: divider remainder width (below 6*chroma). NW: dividend width.
  localparam int W  = rhc_pkg::ChannelBits;
  localparam int Q  = W + 1;
  localparam int RW = W + 3;
  localparam int NW = 2 * W + 3;
  localparam logic [W-1:0] ChMax = {W{1'b1}};

  // The pipe never holds off a transaction.
  assign busy = 1'b0;

  // Direction register: 0 converts RGB forward, 1 rebuilds RGB.
  logic dir_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  // Clamp of a doubled value to the channel range with round-half-up halving.
  function automatic logic [W-1:0] clamp_div2(input logic signed [W+2:0] twice);
    logic signed [W+2:0] half;
    half = (twice + (W+3)'(1)) >>> 1;
    if (twice <= 0) begin
      clamp_div2 = '0;
    end else if (half > $signed({3'b000, ChMax})) begin
      clamp_div2 = ChMax;
    end else begin
      clamp_div2 = half[W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stage 1: register the pixel, find max/min and the sector of the largest
  // channel (ties go to red, then green, then blue). For the inverse, split
  // 6*hue into a sector and a fraction, mirrored in the falling sectors.
  // ---------------------------------------------------------------------------
  logic                  s1_vld_q, s1_dir_q;
  logic [W-1:0]          s1_a_q, s1_b_q, s1_c_q, s1_mx_q, s1_mn_q;
  logic [1:0]            s1_sel_q;
  logic [2:0]            s1_sec_q;
  logic [W:0]            s1_fn_q;

  logic [W-1:0] mx_d, mn_d;
  logic [1:0]   sel_d;
  logic [W+2:0] h6;
  logic [2:0]   sec_d;
  logic [W:0]   fn_d;

  always_comb begin
    if (pix_i.chan_a >= pix_i.chan_c && pix_i.chan_a >= pix_i.chan_b) begin
      mx_d = pix_i.chan_a; sel_d = 2'd0;
    end else if (pix_i.chan_b >= pix_i.chan_a && pix_i.chan_b >= pix_i.chan_c) begin
      mx_d = pix_i.chan_b; sel_d = 2'd1;
    end else begin
      mx_d = pix_i.chan_c; sel_d = 2'd2;
    end
    mn_d = pix_i.chan_a;
    if (pix_i.chan_b < mn_d) mn_d = pix_i.chan_b;
    if (pix_i.chan_c < mn_d) mn_d = pix_i.chan_c;
    h6    = {pix_i.chan_a, 2'b00} + {1'b0, pix_i.chan_a, 1'b0};
    sec_d = h6[W+2:W];
    if (sec_d[0]) begin
      fn_d = {1'b1, {W{1'b0}}} - {1'b0, h6[W-1:0]};
    end else begin
      fn_d = {1'b0, h6[W-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dir_q <= dir_q;
    s1_a_q   <= pix_i.chan_a;
    s1_b_q   <= pix_i.chan_b;
    s1_c_q   <= pix_i.chan_c;
    s1_mx_q  <= mx_d;
    s1_mn_q  <= mn_d;
    s1_sel_q <= sel_d;
    s1_sec_q <= sec_d;
    s1_fn_q  <= fn_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: chroma, lightness and the hue dividend/divisor for the forward
  // direction; the scaled middle channel product for the inverse.
  // Hue = floor((m*2^W + 3*del) / (6*del)), m = sector offset plus difference.
  // ---------------------------------------------------------------------------
  logic                    s2_vld_q, s2_dir_q, s2_gray_q;
  logic [NW-1:0]           s2_n_q;
  logic [RW-1:0]           s2_den_q;
  logic [W-1:0]            s2_light_q, s2_del_q, s2_v_q;
  logic signed [2*W+3:0]   s2_mid2t_q;
  logic signed [W+2:0]     s2_min2_q, s2_max2_q;
  logic [2:0]              s2_sec_q;

  logic [W-1:0]          del_d;
  logic signed [W+3:0]   m_raw, m_fix, del6;
  logic [W:0]            lsum;
  logic [NW-1:0]         n_d;
  logic [2*W:0]          prod;
  logic signed [2*W+3:0] mid2t_d;
  logic signed [W+2:0]   min2_d, max2_d;

  always_comb begin
    del_d = s1_mx_q - s1_mn_q;
    del6  = $signed({4'b0000, del_d}) * $signed((W+4)'(6));
    case (s1_sel_q)
      2'd0:    m_raw = $signed({4'b0000, s1_b_q}) - $signed({4'b0000, s1_c_q});
      2'd1:    m_raw = $signed({3'b000, del_d, 1'b0}) + $signed({4'b0000, s1_c_q})
                       - $signed({4'b0000, s1_a_q});
      default: m_raw = $signed({2'b00, del_d, 2'b00}) + $signed({4'b0000, s1_a_q})
                       - $signed({4'b0000, s1_b_q});
    endcase
    m_fix = (m_raw < 0) ? (m_raw + del6) : m_raw;
    n_d   = {m_fix[W+2:0], {W{1'b0}}} + NW'({del_d, 1'b0}) + NW'(del_d);
    lsum  = {1'b0, s1_mx_q} + {1'b0, s1_mn_q} + (W+1)'(1);
    // Inverse: twice the minimum and maximum, and 2*fn*s + min2*2^W.
    min2_d  = $signed({2'b00, s1_b_q, 1'b0}) - $signed({3'b000, s1_c_q});
    max2_d  = $signed({2'b00, s1_b_q, 1'b0}) + $signed({3'b000, s1_c_q});
    prod    = s1_fn_q * s1_c_q;
    mid2t_d = $signed({2'b00, prod, 1'b0}) + ((2*W+4)'(min2_d) <<< W);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_dir_q   <= s1_dir_q;
    s2_gray_q  <= s1_dir_q ? (s1_c_q == '0) : (del_d == '0);
    s2_n_q     <= n_d;
    s2_den_q   <= RW'(del6);
    s2_light_q <= lsum[W:1];
    s2_del_q   <= del_d;
    s2_v_q     <= s1_b_q;
    s2_mid2t_q <= mid2t_d;
    s2_min2_q  <= min2_d;
    s2_max2_q  <= max2_d;
    s2_sec_q   <= s1_sec_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: load the divider; finish the inverse with clamping and the
  // sector swizzle. The inverse result then rides along the divider stages.
  // ---------------------------------------------------------------------------
  logic                  dv_vld_q [0:Q];
  logic                  dv_fwd_q [0:Q];
  logic [RW-1:0]         dv_rem_q [0:Q];
  logic [Q-1:0]          dv_nlo_q [0:Q];
  logic [RW-1:0]         dv_den_q [0:Q];
  logic [Q-1:0]          dv_quo_q [0:Q];
  rhc_pkg::pix_out_t     dv_res_q [0:Q];

  logic [W-1:0]          lo_d, hi_d, mid_d;
  logic signed [2*W+3:0] mid_sh;
  rhc_pkg::pix_out_t     res_d;

  always_comb begin
    lo_d   = clamp_div2(s2_min2_q);
    hi_d   = clamp_div2(s2_max2_q);
    mid_sh = (s2_mid2t_q + (2*W+4)'(1 << W)) >>> (W + 1);
    if (s2_mid2t_q <= 0) begin
      mid_d = '0;
    end else if (mid_sh > $signed((2*W+4)'(ChMax))) begin
      mid_d = ChMax;
    end else begin
      mid_d = mid_sh[W-1:0];
    end
    if (!s2_dir_q) begin
      res_d = '{out_a: '0, out_b: s2_light_q, out_c: s2_del_q};
    end else if (s2_gray_q) begin
      res_d = '{out_a: s2_v_q, out_b: s2_v_q, out_c: s2_v_q};
    end else begin
      case (s2_sec_q)
        3'd0:    res_d = '{out_a: hi_d,  out_b: mid_d, out_c: lo_d};
        3'd1:    res_d = '{out_a: mid_d, out_b: hi_d,  out_c: lo_d};
        3'd2:    res_d = '{out_a: lo_d,  out_b: hi_d,  out_c: mid_d};
        3'd3:    res_d = '{out_a: lo_d,  out_b: mid_d, out_c: hi_d};
        3'd4:    res_d = '{out_a: mid_d, out_b: lo_d,  out_c: hi_d};
        default: res_d = '{out_a: hi_d,  out_b: lo_d,  out_c: mid_d};
      endcase
    end
  end

  // One quotient bit per stage: bring in the next dividend bit, trial subtract.
  logic [RW:0] trial [1:Q];
  logic [RW:0] diff  [1:Q];
  always_comb begin
    for (int i = 1; i <= Q; i++) begin
      trial[i] = {dv_rem_q[i-1], dv_nlo_q[i-1][Q-1]};
      diff[i]  = trial[i] - {1'b0, dv_den_q[i-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Q; i++) dv_vld_q[i] <= 1'b0;
    end else begin
      dv_vld_q[0] <= s2_vld_q;
      for (int i = 1; i <= Q; i++) dv_vld_q[i] <= dv_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_fwd_q[0] <= !s2_dir_q && !s2_gray_q;
    dv_rem_q[0] <= RW'(s2_n_q[NW-1:Q]);
    dv_nlo_q[0] <= s2_n_q[Q-1:0];
    dv_den_q[0] <= s2_den_q;
    dv_quo_q[0] <= '0;
    dv_res_q[0] <= res_d;
    for (int i = 1; i <= Q; i++) begin
      dv_fwd_q[i] <= dv_fwd_q[i-1];
      dv_nlo_q[i] <= {dv_nlo_q[i-1][Q-2:0], 1'b0};
      dv_den_q[i] <= dv_den_q[i-1];
      dv_res_q[i] <= dv_res_q[i-1];
      if (!diff[i][RW]) begin
        dv_rem_q[i] <= diff[i][RW-1:0];
        dv_quo_q[i] <= {dv_quo_q[i-1][Q-2:0], 1'b1};
      end else begin
        dv_rem_q[i] <= trial[i][RW-1:0];
        dv_quo_q[i] <= {dv_quo_q[i-1][Q-2:0], 1'b0};
      end
    end
  end

  // A full-turn hue wraps to zero by dropping the top quotient bit.
  assign done_o      = dv_vld_q[Q];
  assign pix_o.out_a = dv_fwd_q[Q] ? dv_quo_q[Q][W-1:0] : dv_res_q[Q].out_a;
  assign pix_o.out_b = dv_res_q[Q].out_b;
  assign pix_o.out_c = dv_res_q[Q].out_c;

endmodule
